// ===== rtl/mgtg_pkg.sv =====
// Shared types and constants for the metronome gated tone generator.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package mgtg_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam int SPB_W      = 20;
  localparam int STEP_W     = 32;
  localparam int PAT_W      = 64;
  localparam int PLEN_W     = 7;
  localparam int BIDX_W     = 6;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 12;

  localparam logic [PLEN_W-1:0] PATTERN_MAX = 7'd64;

  localparam logic [SAMPLE_W-1:0] CLICK_VALUE = 16'd15000;

  localparam logic [SPB_W-1:0]  SPB_RESET  = 20'd24000;
  localparam logic [STEP_W-1:0] STEP_RESET = 32'd39370534;
  localparam logic [PAT_W-1:0]  PAT_RESET  = 64'd1;
  localparam logic [PLEN_W-1:0] PLEN_RESET = 7'd1;

  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SAMPLES_PER_BEAT = 2'd0,
    REG_PHASE_STEP       = 2'd1,
    REG_PATTERN_BITS     = 2'd2,
    REG_PATTERN_LENGTH   = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/metronome_gated_tone_generator.sv =====
// The sample for an accepted tick request appears on the output register in the next cycle.
// Throughput: one tick per cycle; the output register lets a new request in whenever
// the held result is taken in the same cycle or none is held.
// Reset (rst_n low at a clock edge): configuration returns to its defaults,
// phase, beat position, beat index and the started flag clear, output goes invalid.
// Depends on mgtg_pkg; sine quarter table is built at elaboration.
`timescale 1ns / 1ps
`default_nettype none

module metronome_gated_tone_generator #(
  parameter int SINE_TABLE_SIZE = 1024,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [mgtg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [mgtg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [0] restart
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [31:0]                             out_tdata,  // [15:0] left, [31:16] right
  output logic [0:0]                              out_tuser   // [0] beat_start
);

  localparam int IDX_W   = $clog2(SINE_TABLE_SIZE);
  localparam int QUARTER = SINE_TABLE_SIZE / 4;
  localparam int Q_W     = IDX_W - 2;
  localparam int MAG_W   = mgtg_pkg::MAG_W;
  localparam int SW      = mgtg_pkg::SAMPLE_W;

  localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(SINE_TABLE_SIZE / 2);
  localparam logic [IDX_W-1:0] QTR_IDX  = IDX_W'(SINE_TABLE_SIZE / 4);

  // Q61 fixed-point product, truncated
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, ll, m1, m2, hh, t, lo, hi;
    ah = a >> 32;
    al = a & 64'hFFFF_FFFF;
    bh = b >> 32;
    bl = b & 64'hFFFF_FFFF;
    ll = al * bl;
    m1 = ah * bl;
    m2 = al * bh;
    hh = ah * bh;
    t  = (ll >> 32) + (m1 & 64'hFFFF_FFFF) + (m2 & 64'hFFFF_FFFF);
    lo = (t << 32) | (ll & 64'hFFFF_FFFF);
    hi = hh + (m1 >> 32) + (m2 >> 32) + (t >> 32);
    return (hi << 3) | (lo >> 61);
  endfunction

  function automatic logic [63:0] taylor_div(input logic [63:0] v, input int k);
    case (k)
      1:       return v / 64'd6;
      2:       return v / 64'd20;
      3:       return v / 64'd42;
      4:       return v / 64'd72;
      5:       return v / 64'd110;
      6:       return v / 64'd156;
      7:       return v / 64'd210;
      8:       return v / 64'd272;
      9:       return v / 64'd342;
      10:      return v / 64'd420;
      11:      return v / 64'd506;
      12:      return v / 64'd600;
      default: return v;
    endcase
  endfunction

  // trunc(3276.7 * sin(pi * m / SINE_TABLE_SIZE))
  function automatic logic [MAG_W-1:0] sine_mag(input logic [63:0] m);
    logic [63:0] x, x2, term, sum, hi, lo, scaled;
    x = (mgtg_pkg::PI_Q61 / SINE_TABLE_SIZE) * m
      + ((mgtg_pkg::PI_Q61 % SINE_TABLE_SIZE) * m) / SINE_TABLE_SIZE;
    x2   = mul_q61(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 12; k++) begin
      term = taylor_div(mul_q61(term, x2), k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    hi = sum >> 32;
    lo = sum & 64'hFFFF_FFFF;
    scaled = hi * 64'd32767 + ((lo * 64'd32767) >> 32);
    return MAG_W'(scaled / 64'd5368709120);
  endfunction

  function automatic logic [QUARTER*MAG_W-1:0] build_tab();
    logic [QUARTER*MAG_W-1:0] tab;
    tab = '0;
    for (int j = 0; j < QUARTER; j++) begin
      tab[j*MAG_W +: MAG_W] = sine_mag(64'(2 * j));
    end
    return tab;
  endfunction

  localparam logic [QUARTER*MAG_W-1:0] SINE_TAB  = build_tab();
  localparam logic [MAG_W-1:0]         SINE_PEAK = sine_mag(64'(SINE_TABLE_SIZE / 2));

  // configuration
  logic [mgtg_pkg::SPB_W-1:0]  spb_r;
  logic [mgtg_pkg::STEP_W-1:0] step_r;
  logic [mgtg_pkg::PAT_W-1:0]  pat_r;
  logic [mgtg_pkg::PLEN_W-1:0] plen_r;

  // tick state
  logic [PHASE_BITS-1:0]        phase_r, phase_nxt;
  logic [mgtg_pkg::SPB_W-1:0]   pos_r, pos_nxt;
  logic [mgtg_pkg::BIDX_W-1:0]  bidx_r, bidx_nxt;
  logic                         started_r;

  // output register
  logic          out_valid_r;
  logic [SW-1:0] out_sample_r, sample_nxt;
  logic          out_beat_r, click_nxt;

  logic                        accept;
  logic                        restart;
  logic [PHASE_BITS-1:0]       phase_base;
  logic [mgtg_pkg::SPB_W-1:0]  pos_base;
  logic [mgtg_pkg::BIDX_W-1:0] bidx_base;
  logic                        started_base;
  logic [mgtg_pkg::SPB_W-1:0]  spb_eff;
  logic [mgtg_pkg::PLEN_W-1:0] plen_eff;
  logic [mgtg_pkg::SPB_W:0]    pos_inc;
  logic [mgtg_pkg::PLEN_W-1:0] bidx_inc;
  logic                        wrap;
  logic [PHASE_BITS+31:0]      phase_sum;

  logic [IDX_W-1:0]  idx, kk, q;
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [SW-1:0]     sine_val;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign restart   = in_tdata[0];

  always_comb begin
    phase_base   = restart ? '0 : phase_r;
    pos_base     = restart ? '0 : pos_r;
    bidx_base    = restart ? '0 : bidx_r;
    started_base = restart ? 1'b0 : started_r;

    spb_eff  = (spb_r == '0) ? mgtg_pkg::SPB_W'(1) : spb_r;
    if (plen_r == '0) begin
      plen_eff = mgtg_pkg::PLEN_W'(1);
    end else if (plen_r > mgtg_pkg::PATTERN_MAX) begin
      plen_eff = mgtg_pkg::PATTERN_MAX;
    end else begin
      plen_eff = plen_r;
    end

    phase_sum = {32'd0, phase_base} + {{PHASE_BITS{1'b0}}, step_r};
    phase_nxt = phase_sum[PHASE_BITS-1:0];

    pos_inc  = {1'b0, pos_base} + (mgtg_pkg::SPB_W+1)'(1);
    bidx_inc = {1'b0, bidx_base} + mgtg_pkg::PLEN_W'(1);
    wrap     = pos_inc >= {1'b0, spb_eff};
    if (wrap) begin
      pos_nxt  = '0;
      bidx_nxt = (bidx_inc >= plen_eff) ? '0 : bidx_inc[mgtg_pkg::BIDX_W-1:0];
    end else begin
      pos_nxt  = pos_inc[mgtg_pkg::SPB_W-1:0];
      bidx_nxt = bidx_base;
    end
    click_nxt = wrap || !started_base;

    // fold the table index onto the first quarter wave
    idx = phase_nxt[PHASE_BITS-1 -: IDX_W];
    neg = idx > HALF_IDX;
    kk  = neg ? (IDX_W'(0) - idx) : idx;
    q   = (kk > QTR_IDX) ? (HALF_IDX - kk) : kk;
    mag = (q == QTR_IDX) ? SINE_PEAK : SINE_TAB[q[Q_W-1:0]*MAG_W +: MAG_W];
    sine_val = neg ? (SW'(0) - {{(SW-MAG_W){1'b0}}, mag}) : {{(SW-MAG_W){1'b0}}, mag};

    if (click_nxt) begin
      sample_nxt = mgtg_pkg::CLICK_VALUE;
    end else if (pat_r[bidx_nxt]) begin
      sample_nxt = sine_val;
    end else begin
      sample_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r  <= mgtg_pkg::SPB_RESET;
      step_r <= mgtg_pkg::STEP_RESET;
      pat_r  <= mgtg_pkg::PAT_RESET;
      plen_r <= mgtg_pkg::PLEN_RESET;
    end else if (cfg_wr_en) begin
      case (mgtg_pkg::cfg_reg_t'(cfg_addr))
        mgtg_pkg::REG_SAMPLES_PER_BEAT: spb_r  <= cfg_wdata[mgtg_pkg::SPB_W-1:0];
        mgtg_pkg::REG_PHASE_STEP:       step_r <= cfg_wdata[mgtg_pkg::STEP_W-1:0];
        mgtg_pkg::REG_PATTERN_BITS:     pat_r  <= cfg_wdata[mgtg_pkg::PAT_W-1:0];
        mgtg_pkg::REG_PATTERN_LENGTH:   plen_r <= cfg_wdata[mgtg_pkg::PLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      pos_r       <= '0;
      bidx_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      bidx_r      <= bidx_nxt;
      started_r   <= 1'b1;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_sample_r <= sample_nxt;
      out_beat_r   <= click_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_sample_r, out_sample_r};
  assign out_tuser[0] = out_beat_r;

endmodule

`default_nettype wire

// ===== rtl/mgtg_checker.sv =====
// Port-level checks for the metronome gated tone generator, bound to the top level.
// Depends on mgtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgtg_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [7:0]                      in_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [31:0]                     out_tdata,
  input wire logic [0:0]                      out_tuser
);

  a_click_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[15:0] == mgtg_pkg::CLICK_VALUE)
    else $error("beat_start without click value");

  a_stereo_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] == out_tdata[31:16])
    else $error("left and right samples differ");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request produced no result");

  a_restart_clicks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[0] |=> out_tuser[0])
    else $error("restart request did not click");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind metronome_gated_tone_generator mgtg_checker u_mgtg_checker (.*);

`default_nettype wire
